// ----- rtl/cc3d_pkg.sv -----
package cc3d_pkg;

  // Field widths
  localparam int IN_W       = 16;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 32;

  // Datapath widths, all exact
  localparam int DW   = COORD_BITS + 1;        // edge vector component
  localparam int PW   = 2 * DW;                // product of two components
  localparam int WW   = PW + 1;                // normal vector component
  localparam int SQW  = PW + 2;                // squared edge length
  localparam int DENW = 2 * WW + 3;            // 2 * |w|^2, signed
  localparam int VWW  = DW + WW + 1;           // cross product with the normal
  localparam int NW   = SQW + VWW + 2;         // numerator before scaling
  localparam int MW   = NW + FRAC_BITS;        // scaled numerator magnitude
  localparam int RW   = (MW > DENW - 1 + OUT_W) ? MW : DENW - 1 + OUT_W;
  localparam int LV   = VWW / 2;               // low slice of the cross terms
  localparam int LD   = DENW / 2;              // low slice of the determinant

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t a [3];
    coord_t b [3];
    coord_t c [3];
  } pts_t;

  typedef struct {
    coord_t                  a  [3];
    logic signed [DENW-1:0]  den;
    logic signed [SQW-1:0]   uu;
    logic signed [SQW-1:0]   vv;
    logic signed [VWW-1:0]   vw [3];
    logic signed [VWW-1:0]   wu [3];
  } front_t;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0]         neg;
    logic [2:0]         big;
    logic [DENW-2:0]    den;
    logic               degen;
  } numer_t;

  typedef struct packed {
    logic [2:0][RW-1:0]    rem;
    logic [2:0][OUT_W-1:0] q;
    logic [2:0]            neg;
    logic [2:0]            big;
    logic [DENW-2:0]       den;
    logic                  degen;
  } dstg_t;

  typedef struct packed {
    logic [2:0][OUT_W-1:0] center;
    logic                  degen;
    logic                  ovf;
  } result_t;

  // Cyclic neighbors of an axis
  function automatic int rot1(input int k);
    rot1 = (k == 2) ? 0 : k + 1;
  endfunction

  function automatic int rot2(input int k);
    rot2 = (k == 0) ? 2 : k - 1;
  endfunction

endpackage

// ----- rtl/cc3d_front.sv -----
module cc3d_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cc3d_pkg::pts_t  pts,
  output logic            out_valid,
  input  logic            out_stall,
  output cc3d_pkg::front_t res
);
  import cc3d_pkg::*;

  localparam int NS = 5;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  coord_t                    a1 [3];
  logic signed [DW-1:0]      u1 [3];
  logic signed [DW-1:0]      v1 [3];
  coord_t                    a2 [3];
  logic signed [DW-1:0]      u2 [3];
  logic signed [DW-1:0]      v2 [3];
  logic signed [PW-1:0]      m1 [3];
  logic signed [PW-1:0]      m2 [3];
  logic signed [PW-1:0]      su [3];
  logic signed [PW-1:0]      sv [3];
  coord_t                    a3 [3];
  logic signed [DW-1:0]      u3 [3];
  logic signed [DW-1:0]      v3 [3];
  logic signed [WW-1:0]      w3 [3];
  logic signed [SQW-1:0]     uu3;
  logic signed [SQW-1:0]     vv3;
  coord_t                    a4 [3];
  logic signed [SQW-1:0]     uu4;
  logic signed [SQW-1:0]     vv4;
  logic signed [2*WW-1:0]    ww4 [3];
  logic signed [DW+WW-1:0]   pv1 [3];
  logic signed [DW+WW-1:0]   pv2 [3];
  logic signed [DW+WW-1:0]   pu1 [3];
  logic signed [DW+WW-1:0]   pu2 [3];

  // Advance a stage when it is empty or the next one moves
  assign en[NS-1] = !vld[NS-1] || !out_stall;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end
  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Edge vectors from the first point
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        a1[k] <= pts.a[k];
        u1[k] <= DW'(pts.b[k]) - DW'(pts.a[k]);
        v1[k] <= DW'(pts.c[k]) - DW'(pts.a[k]);
      end
    end
  end

  // Cross and square products of the edges
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        a2[k] <= a1[k];
        u2[k] <= u1[k];
        v2[k] <= v1[k];
        m1[k] <= u1[rot1(k)] * v1[rot2(k)];
        m2[k] <= u1[rot2(k)] * v1[rot1(k)];
        su[k] <= u1[k] * u1[k];
        sv[k] <= v1[k] * v1[k];
      end
    end
  end

  // Normal vector and squared edge lengths
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        a3[k] <= a2[k];
        u3[k] <= u2[k];
        v3[k] <= v2[k];
        w3[k] <= WW'(m1[k]) - WW'(m2[k]);
      end
      uu3 <= SQW'(su[0]) + SQW'(su[1]) + SQW'(su[2]);
      vv3 <= SQW'(sv[0]) + SQW'(sv[1]) + SQW'(sv[2]);
    end
  end

  // Products for the determinant and the cross terms
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        a4[k]  <= a3[k];
        ww4[k] <= w3[k] * w3[k];
        pv1[k] <= v3[rot1(k)] * w3[rot2(k)];
        pv2[k] <= v3[rot2(k)] * w3[rot1(k)];
        pu1[k] <= w3[rot1(k)] * u3[rot2(k)];
        pu2[k] <= w3[rot2(k)] * u3[rot1(k)];
      end
      uu4 <= uu3;
      vv4 <= vv3;
    end
  end

  // Determinant and cross terms
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        res.a[k]  <= a4[k];
        res.vw[k] <= VWW'(pv1[k]) - VWW'(pv2[k]);
        res.wu[k] <= VWW'(pu1[k]) - VWW'(pu2[k]);
      end
      res.den <= (DENW'(ww4[0]) + DENW'(ww4[1]) + DENW'(ww4[2])) <<< 1;
      res.uu  <= uu4;
      res.vv  <= vv4;
    end
  end

endmodule

// ----- rtl/cc3d_numer.sv -----
module cc3d_numer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cc3d_pkg::front_t f,
  output logic             out_valid,
  input  logic             out_stall,
  output cc3d_pkg::numer_t res
);
  import cc3d_pkg::*;

  localparam int NS  = 5;
  localparam int ULW = SQW + LV + 1;
  localparam int UHW = SQW + VWW - LV;
  localparam int ALW = COORD_BITS + LD + 1;
  localparam int AHW = COORD_BITS + DENW - LD;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [ULW-1:0]  uvl [3];
  logic signed [UHW-1:0]  uvh [3];
  logic signed [ULW-1:0]  vwl [3];
  logic signed [UHW-1:0]  vwh [3];
  logic signed [ALW-1:0]  adl [3];
  logic signed [AHW-1:0]  adh [3];
  logic [DENW-2:0]        den1, den2, den3, den4;
  logic                   dg1, dg2, dg3, dg4;
  logic signed [NW-1:0]   t1 [3];
  logic signed [NW-1:0]   t2 [3];
  logic signed [NW-1:0]   t3 [3];
  logic signed [NW-1:0]   num [3];
  logic [NW-1:0]          absn [3];
  logic [2:0][MW-1:0]     mag4;
  logic [2:0]             neg4;

  assign en[NS-1] = !vld[NS-1] || !out_stall;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end
  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Partial products, wide operands split in two slices
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        uvl[k] <= f.uu * $signed({1'b0, f.vw[k][LV-1:0]});
        uvh[k] <= f.uu * $signed(f.vw[k][VWW-1:LV]);
        vwl[k] <= f.vv * $signed({1'b0, f.wu[k][LV-1:0]});
        vwh[k] <= f.vv * $signed(f.wu[k][VWW-1:LV]);
        adl[k] <= f.a[k] * $signed({1'b0, f.den[LD-1:0]});
        adh[k] <= f.a[k] * $signed(f.den[DENW-1:LD]);
      end
      den1 <= f.den[DENW-2:0];
      dg1  <= (f.den == '0);
    end
  end

  // Merge slices
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        t1[k] <= (NW'(uvh[k]) <<< LV) + NW'(uvl[k]);
        t2[k] <= (NW'(vwh[k]) <<< LV) + NW'(vwl[k]);
        t3[k] <= (NW'(adh[k]) <<< LD) + NW'(adl[k]);
      end
      den2 <= den1;
      dg2  <= dg1;
    end
  end

  // Full numerator including the offset of the first point
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        num[k] <= t1[k] + t2[k] + t3[k];
      end
      den3 <= den2;
      dg3  <= dg2;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      absn[k] = num[k][NW-1] ? (~num[k] + 1'b1) : num[k];
    end
  end

  // Sign and scaled magnitude
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        neg4[k] <= num[k][NW-1];
        mag4[k] <= MW'(absn[k]) << FRAC_BITS;
      end
      den4 <= den3;
      dg4  <= dg3;
    end
  end

  // Flag quotients of 2^OUT_W or more
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        res.big[k] <= RW'(mag4[k]) >= (RW'(den4) << OUT_W);
      end
      res.mag   <= mag4;
      res.neg   <= neg4;
      res.den   <= den4;
      res.degen <= dg4;
    end
  end

endmodule

// ----- rtl/cc3d_div.sv -----
module cc3d_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cc3d_pkg::numer_t  n,
  output logic              out_valid,
  input  logic              out_stall,
  output cc3d_pkg::result_t res
);
  import cc3d_pkg::*;

  localparam int NS = OUT_W + 1;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  dstg_t st    [OUT_W];
  dstg_t st_in [OUT_W];
  dstg_t nx    [OUT_W];
  dstg_t last;
  logic [2:0][OUT_W-1:0] cval;
  logic [2:0]            sat;

  assign en[NS-1] = !vld[NS-1] || !out_stall;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end
  assign in_stall  = !en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Feed each step from the one before it
  always_comb begin
    st_in[0].q     = '0;
    st_in[0].neg   = n.neg;
    st_in[0].big   = n.big;
    st_in[0].den   = n.den;
    st_in[0].degen = n.degen;
    for (int k = 0; k < 3; k++) begin
      st_in[0].rem[k] = RW'(n.mag[k]);
    end
    for (int j = 1; j < OUT_W; j++) begin
      st_in[j] = st[j-1];
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    logic [RW-1:0] sh;
    logic          ge;
    for (int j = 0; j < OUT_W; j++) begin
      nx[j] = st_in[j];
      sh    = RW'(st_in[j].den) << (OUT_W - 1 - j);
      for (int k = 0; k < 3; k++) begin
        ge = st_in[j].rem[k] >= sh;
        if (ge) nx[j].rem[k] = st_in[j].rem[k] - sh;
        nx[j].q[k][OUT_W-1-j] = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < OUT_W; j++) begin
      if (en[j]) st[j] <= nx[j];
    end
  end

  // Apply sign and saturate
  assign last = st[OUT_W-1];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat[k] = last.big[k] ||
               (last.neg[k] ? (last.q[k][OUT_W-1] && (|last.q[k][OUT_W-2:0]))
                            : last.q[k][OUT_W-1]);
      if (last.degen) begin
        cval[k] = '0;
      end else if (sat[k]) begin
        cval[k] = last.neg[k] ? SAT_MIN : SAT_MAX;
      end else begin
        cval[k] = last.neg[k] ? (~last.q[k] + 1'b1) : last.q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      res.center <= cval;
      res.degen  <= last.degen;
      res.ovf    <= !last.degen && (|sat);
    end
  end

endmodule

// ----- rtl/circumcenter_three_points_3d_top.sv -----
// Circumcenter of three 3D points, fully pipelined over 43 register stages.
// Each item passes through the front, numerator and divider pipelines in that order.
// Throughput: one item per cycle while the output is not stalled; the 32 one-bit divider steps set the depth.
// Each stage holds while its successor is full, so stalls lose nothing.
// Reset (rst, synchronous, active high) empties the pipeline; no other state.
module circumcenter_three_points_3d_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_a_x,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_a_y,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_a_z,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_b_x,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_b_y,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_b_z,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_c_x,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_c_y,
  input  logic signed [cc3d_pkg::IN_W-1:0] point_c_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [cc3d_pkg::OUT_W-1:0] center_x,
  output logic signed [cc3d_pkg::OUT_W-1:0] center_y,
  output logic signed [cc3d_pkg::OUT_W-1:0] center_z,
  output logic                           degenerate,
  output logic                           overflow
);
  import cc3d_pkg::*;

  pts_t    pts;
  front_t  fr;
  numer_t  nm;
  result_t rs;
  logic    fr_valid, fr_stall;
  logic    nm_valid, nm_stall;

  // Keep the low coordinate bits as signed values
  always_comb begin
    pts.a[0] = point_a_x[COORD_BITS-1:0];
    pts.a[1] = point_a_y[COORD_BITS-1:0];
    pts.a[2] = point_a_z[COORD_BITS-1:0];
    pts.b[0] = point_b_x[COORD_BITS-1:0];
    pts.b[1] = point_b_y[COORD_BITS-1:0];
    pts.b[2] = point_b_z[COORD_BITS-1:0];
    pts.c[0] = point_c_x[COORD_BITS-1:0];
    pts.c[1] = point_c_y[COORD_BITS-1:0];
    pts.c[2] = point_c_z[COORD_BITS-1:0];
  end

  cc3d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pts       (pts),
    .out_valid (fr_valid),
    .out_stall (fr_stall),
    .res       (fr)
  );

  cc3d_numer u_numer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_stall  (fr_stall),
    .f         (fr),
    .out_valid (nm_valid),
    .out_stall (nm_stall),
    .res       (nm)
  );

  cc3d_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nm_valid),
    .in_stall  (nm_stall),
    .n         (nm),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (rs)
  );

  assign center_x   = rs.center[0];
  assign center_y   = rs.center[1];
  assign center_z   = rs.center[2];
  assign degenerate = rs.degen;
  assign overflow   = rs.ovf;

  // Degenerate results carry a zero center and no overflow
  assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      center_x == '0 && center_y == '0 && center_z == '0 && !overflow)
    else $error("degenerate result with nonzero center or overflow");

  // Overflow only with a saturated coordinate
  assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      center_x == SAT_MAX || center_x == SAT_MIN ||
      center_y == SAT_MAX || center_y == SAT_MIN ||
      center_z == SAT_MAX || center_z == SAT_MIN)
    else $error("overflow without a saturated coordinate");

  // Input holds back only when the pipeline is full behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && fr_valid && nm_valid)
    else $error("input stalled while pipeline has room");

  // The pipeline is empty right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
